// ===== hw/rtl/adjacency_list_edge_engine_core_assert.svh =====
// Assertion macros for the adjacency-list edge engine RTL.
`ifndef ADJACENCY_LIST_EDGE_ENGINE_CORE_ASSERT_SVH
`define ADJACENCY_LIST_EDGE_ENGINE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ALEE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("edge engine check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ALEE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("edge engine check failed");

`endif

// ===== hw/rtl/alee_pkg.sv =====
// Package: sizes, codes, request structs and slot addressing for the edge engine.
`default_nettype none
package alee_pkg;
	localparam int VERTICES   = 64;
	localparam int MAX_DEGREE = 16;

	localparam int VIDX_W  = 6;
	localparam int DEG_W   = 5;
	localparam int CNT_W   = 7;
	localparam int WGT_W   = 32;
	localparam int STAT_W  = 2;
	localparam int SLOT_W  = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
	localparam int ADDR_W  = $clog2(VERTICES * MAX_DEGREE);
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
	localparam logic [STAT_W-1:0] ST_RANGE   = 2'd1;
	localparam logic [STAT_W-1:0] ST_MISSING = 2'd2;
	localparam logic [STAT_W-1:0] ST_FULL    = 2'd3;

	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_REMOVE = 1'b1;

	localparam logic REG_VCOUNT   = 1'b0;
	localparam logic REG_WEIGHTED = 1'b1;

	typedef struct packed {
		logic [CNT_W-1:0] vcount;
		logic             weighted;
	} cfg_t;

	typedef struct packed {
		logic              en;
		logic [VIDX_W-1:0] addr;
		logic [DEG_W-1:0]  data;
	} deg_wr_t;

	typedef struct packed {
		logic              en;
		logic              w_en;
		logic [ADDR_W-1:0] addr;
		logic [VIDX_W-1:0] nb;
		logic [WGT_W-1:0]  w;
	} list_wr_t;

	function automatic logic [ADDR_W-1:0] slot_addr(input logic [VIDX_W-1:0] v,
			input logic [SLOT_W-1:0] k);
		slot_addr = ADDR_W'(ADDR_W'(v) * ADDR_W'(MAX_DEGREE) + ADDR_W'(k));
	endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/alee_deg_mem.sv =====
// Degree table: per-vertex degree memory with valid bits cleared at reset.
`default_nettype none
module alee_deg_mem (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic [alee_pkg::VIDX_W-1:0]       rd_addr,
	output logic [alee_pkg::DEG_W-1:0]             rd_data,
	input  wire alee_pkg::deg_wr_t                 wr
);
	logic [alee_pkg::DEG_W-1:0] mem [alee_pkg::VERTICES];
	logic [alee_pkg::VERTICES-1:0] valid_q;
	logic [alee_pkg::DEG_W-1:0] rd_data_q;
	logic rd_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			rd_vld_q <= valid_q[rd_addr];
			if (wr.en) begin
				valid_q[wr.addr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	// never-written entries read as zero
	assign rd_data = rd_vld_q ? rd_data_q : '0;
endmodule
`default_nettype wire

// ===== hw/rtl/alee_list_mem.sv =====
// Neighbor and weight stores: one write and one registered read per cycle.
`default_nettype none
module alee_list_mem (
	input  wire logic                              clk,
	input  wire logic [alee_pkg::ADDR_W-1:0]       rd_addr,
	output logic [alee_pkg::VIDX_W-1:0]            rd_nb,
	output logic [alee_pkg::WGT_W-1:0]             rd_w,
	input  wire alee_pkg::list_wr_t                wr
);
	logic [alee_pkg::VIDX_W-1:0] nb_mem [alee_pkg::VERTICES * alee_pkg::MAX_DEGREE];
	logic [alee_pkg::WGT_W-1:0]  w_mem  [alee_pkg::VERTICES * alee_pkg::MAX_DEGREE];

	always_ff @(posedge clk) begin
		rd_nb <= nb_mem[rd_addr];
		if (wr.en) begin
			nb_mem[wr.addr] <= wr.nb;
		end
	end

	always_ff @(posedge clk) begin
		rd_w <= w_mem[rd_addr];
		if (wr.en && wr.w_en) begin
			w_mem[wr.addr] <= wr.w;
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/alee_ctrl.sv =====
// Sequencer: range check, list append, list scan with move-last, result register.
`default_nettype none
`include "adjacency_list_edge_engine_core_assert.svh"
module alee_ctrl (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire alee_pkg::cfg_t                    cfg,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic                              mode,
	input  wire logic [alee_pkg::VIDX_W-1:0]       origin_vertex,
	input  wire logic [alee_pkg::VIDX_W-1:0]       dest_vertex,
	input  wire logic                              directed,
	input  wire logic [alee_pkg::WGT_W-1:0]        edge_weight,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [alee_pkg::STAT_W-1:0]            status,
	output logic [alee_pkg::DEG_W-1:0]             origin_degree,
	output logic [alee_pkg::VIDX_W-1:0]            deg_rd_addr,
	input  wire logic [alee_pkg::DEG_W-1:0]        deg_rd_data,
	output alee_pkg::deg_wr_t                      deg_wr,
	output logic [alee_pkg::ADDR_W-1:0]            list_rd_addr,
	input  wire logic [alee_pkg::VIDX_W-1:0]       list_rd_nb,
	input  wire logic [alee_pkg::WGT_W-1:0]        list_rd_w,
	output alee_pkg::list_wr_t                     list_wr
);
	typedef enum logic [3:0] {
		S_IDLE, S_DEG_RD, S_DEG_USE, S_SCAN, S_MOVE_RD, S_MOVE_WR, S_FIN_RD, S_FIN, S_RESULT
	} state_t;

	state_t state_q;
	logic mode_q, dir_q, pass_q, cmp_vld_q, out_valid_q;
	logic [alee_pkg::VIDX_W-1:0] orig_q, dest_q;
	logic [alee_pkg::WGT_W-1:0] w_q;
	logic [alee_pkg::DEG_W-1:0] deg_q, rd_idx_q, res_deg_q, out_deg_q;
	logic [alee_pkg::SLOT_W-1:0] cmp_idx_q, hole_q;
	logic [alee_pkg::STAT_W-1:0] status_q, out_status_q;

	logic [alee_pkg::VIDX_W-1:0] cur_v, cur_nb;
	logic [alee_pkg::DEG_W-1:0] deg_last;
	logic [alee_pkg::CNT_W-1:0] limit;
	logic in_range, add_ok, hit, scan_end, rev_next;
	logic [alee_pkg::STAT_W-1:0] fail_status;
	logic deg_ok, range_out;

	always_comb begin
		cur_v    = pass_q ? dest_q : orig_q;
		cur_nb   = pass_q ? orig_q : dest_q;
		deg_last = deg_q - alee_pkg::DEG_W'(1);
		limit    = (cfg.vcount > alee_pkg::CNT_W'(alee_pkg::VERTICES)) ?
			alee_pkg::CNT_W'(alee_pkg::VERTICES) : cfg.vcount;
		in_range = (alee_pkg::CNT_W'(origin_vertex) < limit) &&
			(alee_pkg::CNT_W'(dest_vertex) < limit);
		add_ok   = deg_rd_data < alee_pkg::DEG_W'(alee_pkg::MAX_DEGREE);
		hit      = cmp_vld_q && (list_rd_nb == cur_nb);
		scan_end = alee_pkg::DEG_W'(cmp_idx_q) == deg_last;
		rev_next = !pass_q && !dir_q;
		// a missing reverse edge is ignored; a full reverse list still reports full
		if (!pass_q) begin
			fail_status = (mode_q == alee_pkg::MODE_REMOVE) ? alee_pkg::ST_MISSING :
				alee_pkg::ST_FULL;
		end else begin
			fail_status = (mode_q == alee_pkg::MODE_REMOVE) ? status_q : alee_pkg::ST_FULL;
		end

		deg_rd_addr  = (state_q == S_FIN_RD) ? orig_q : cur_v;
		list_rd_addr = (state_q == S_MOVE_RD) ?
			alee_pkg::slot_addr(cur_v, deg_last[alee_pkg::SLOT_W-1:0]) :
			alee_pkg::slot_addr(cur_v, rd_idx_q[alee_pkg::SLOT_W-1:0]);

		deg_wr  = '0;
		list_wr = '0;
		case (state_q)
			S_DEG_USE: begin
				if (mode_q == alee_pkg::MODE_INSERT && add_ok) begin
					deg_wr.en     = 1'b1;
					deg_wr.addr   = cur_v;
					deg_wr.data   = deg_rd_data + alee_pkg::DEG_W'(1);
					list_wr.en    = 1'b1;
					list_wr.w_en  = cfg.weighted;
					list_wr.addr  = alee_pkg::slot_addr(cur_v,
						deg_rd_data[alee_pkg::SLOT_W-1:0]);
					list_wr.nb    = cur_nb;
					list_wr.w     = w_q;
				end
			end
			S_MOVE_RD: begin
				deg_wr.en   = 1'b1;
				deg_wr.addr = cur_v;
				deg_wr.data = deg_last;
			end
			S_MOVE_WR: begin
				list_wr.en   = 1'b1;
				list_wr.w_en = cfg.weighted;
				list_wr.addr = alee_pkg::slot_addr(cur_v, hole_q);
				list_wr.nb   = list_rd_nb;
				list_wr.w    = list_rd_w;
			end
			default: begin
			end
		endcase
	end

	assign in_ready      = (state_q == S_IDLE);
	assign out_valid     = out_valid_q;
	assign status        = out_status_q;
	assign origin_degree = out_deg_q;

	assign deg_ok    = deg_wr.data <= alee_pkg::DEG_W'(alee_pkg::MAX_DEGREE);
	assign range_out = out_valid_q && (out_status_q == alee_pkg::ST_RANGE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			mode_q       <= 1'b0;
			dir_q        <= 1'b0;
			pass_q       <= 1'b0;
			cmp_vld_q    <= 1'b0;
			out_valid_q  <= 1'b0;
			orig_q       <= '0;
			dest_q       <= '0;
			w_q          <= '0;
			deg_q        <= '0;
			rd_idx_q     <= '0;
			res_deg_q    <= '0;
			out_deg_q    <= '0;
			cmp_idx_q    <= '0;
			hole_q       <= '0;
			status_q     <= alee_pkg::ST_DONE;
			out_status_q <= alee_pkg::ST_DONE;
		end else begin
			// drop a taken result unless the next one refills the register now
			if (out_valid_q && out_ready && state_q != S_RESULT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						mode_q   <= mode;
						orig_q   <= origin_vertex;
						dest_q   <= dest_vertex;
						dir_q    <= directed;
						w_q      <= edge_weight;
						pass_q   <= 1'b0;
						status_q <= in_range ? alee_pkg::ST_DONE : alee_pkg::ST_RANGE;
						res_deg_q <= '0;
						state_q  <= in_range ? S_DEG_RD : S_RESULT;
					end
				end
				S_DEG_RD: begin
					state_q <= S_DEG_USE;
				end
				S_DEG_USE: begin
					if (mode_q == alee_pkg::MODE_INSERT) begin
						if (!add_ok) begin
							status_q <= fail_status;
							pass_q   <= 1'b0;
							state_q  <= S_FIN_RD;
						end else begin
							pass_q  <= rev_next;
							state_q <= rev_next ? S_DEG_RD : S_FIN_RD;
						end
					end else if (deg_rd_data == '0) begin
						status_q <= fail_status;
						pass_q   <= 1'b0;
						state_q  <= S_FIN_RD;
					end else begin
						deg_q     <= deg_rd_data;
						rd_idx_q  <= '0;
						cmp_vld_q <= 1'b0;
						state_q   <= S_SCAN;
					end
				end
				S_SCAN: begin
					// issue one read per cycle, compare the previous one
					rd_idx_q  <= rd_idx_q + alee_pkg::DEG_W'(1);
					cmp_idx_q <= rd_idx_q[alee_pkg::SLOT_W-1:0];
					cmp_vld_q <= 1'b1;
					if (hit) begin
						hole_q  <= cmp_idx_q;
						state_q <= S_MOVE_RD;
					end else if (cmp_vld_q && scan_end) begin
						status_q <= fail_status;
						pass_q   <= 1'b0;
						state_q  <= S_FIN_RD;
					end
				end
				S_MOVE_RD: begin
					state_q <= S_MOVE_WR;
				end
				S_MOVE_WR: begin
					pass_q  <= rev_next;
					state_q <= rev_next ? S_DEG_RD : S_FIN_RD;
				end
				S_FIN_RD: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					res_deg_q <= deg_rd_data;
					state_q   <= S_RESULT;
				end
				S_RESULT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q  <= 1'b1;
						out_status_q <= status_q;
						out_deg_q    <= res_deg_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`ALEE_ASSERT_NXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)
	`ALEE_ASSERT_IMP(a_deg_bound, clk, arst_n, deg_wr.en, deg_ok)
	`ALEE_ASSERT_IMP(a_scan_bound, clk, arst_n, state_q == S_SCAN, rd_idx_q <= deg_q && deg_q != '0)
	`ALEE_ASSERT_IMP(a_range_zero, clk, arst_n, range_out, out_deg_q == '0)
endmodule
`default_nettype wire

// ===== hw/rtl/adjacency_list_edge_engine_core.sv =====
// Top level: APB register file, sequencer and the degree and list stores.
// Sequence: range check, then per direction a degree read and either an append or a
//   list scan with move-last, then a final degree read and the result register.
// Throughput: one request at a time; the input stays closed while a request runs, and a remove
//   scans its list one slot at a time through the single list read port.
// Reset: arst_n clears sequencer and degree valid bits and resets the registers; list stores hold.
`default_nettype none
module adjacency_list_edge_engine_core (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [alee_pkg::PADDR_W-1:0]      paddr,
	input  wire logic [alee_pkg::PDATA_W-1:0]      pwdata,
	output logic [alee_pkg::PDATA_W-1:0]           prdata,
	output logic                                   pready,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic                              mode,
	input  wire logic [alee_pkg::VIDX_W-1:0]       origin_vertex,
	input  wire logic [alee_pkg::VIDX_W-1:0]       dest_vertex,
	input  wire logic                              directed,
	input  wire logic [alee_pkg::WGT_W-1:0]        edge_weight,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [alee_pkg::STAT_W-1:0]            status,
	output logic [alee_pkg::DEG_W-1:0]             origin_degree
);
	alee_pkg::cfg_t cfg_q;
	logic reg_idx;

	logic [alee_pkg::VIDX_W-1:0] deg_rd_addr;
	logic [alee_pkg::DEG_W-1:0]  deg_rd_data;
	alee_pkg::deg_wr_t           deg_wr;
	logic [alee_pkg::ADDR_W-1:0] list_rd_addr;
	logic [alee_pkg::VIDX_W-1:0] list_rd_nb;
	logic [alee_pkg::WGT_W-1:0]  list_rd_w;
	alee_pkg::list_wr_t          list_wr;

	// Registers sit on 4-byte steps; the word index is the only decoded bit.
	assign reg_idx = paddr[2];
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.vcount   <= alee_pkg::CNT_W'(alee_pkg::VERTICES);
			cfg_q.weighted <= 1'b0;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				alee_pkg::REG_VCOUNT:   cfg_q.vcount   <= pwdata[alee_pkg::CNT_W-1:0];
				alee_pkg::REG_WEIGHTED: cfg_q.weighted <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	// Read back the register under the current address.
	always_comb begin
		case (reg_idx)
			alee_pkg::REG_VCOUNT:   prdata = alee_pkg::PDATA_W'(cfg_q.vcount);
			alee_pkg::REG_WEIGHTED: prdata = alee_pkg::PDATA_W'(cfg_q.weighted);
			default:                prdata = '0;
		endcase
	end

	// Sequencer drives both stores and owns the result register.
	alee_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.mode          (mode),
		.origin_vertex (origin_vertex),
		.dest_vertex   (dest_vertex),
		.directed      (directed),
		.edge_weight   (edge_weight),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.origin_degree (origin_degree),
		.deg_rd_addr   (deg_rd_addr),
		.deg_rd_data   (deg_rd_data),
		.deg_wr        (deg_wr),
		.list_rd_addr  (list_rd_addr),
		.list_rd_nb    (list_rd_nb),
		.list_rd_w     (list_rd_w),
		.list_wr       (list_wr)
	);

	// Degree per vertex; valid bits make the table read zero after reset.
	alee_deg_mem u_deg_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (deg_rd_addr),
		.rd_data (deg_rd_data),
		.wr      (deg_wr)
	);

	// Neighbor numbers and weight words, one slot row per vertex.
	alee_list_mem u_list_mem (
		.clk     (clk),
		.rd_addr (list_rd_addr),
		.rd_nb   (list_rd_nb),
		.rd_w    (list_rd_w),
		.wr      (list_wr)
	);
endmodule
`default_nettype wire

// ===== dv/adjacency_list_edge_engine_core_tb.sv =====
// Self-checking testbench for the adjacency-list edge engine against a predictor.
`timescale 1ns / 1ps

module adjacency_list_edge_engine_core_tb;
	import alee_pkg::*;

	// Copies of the adjacency store. The stimulus side steers requests with PLAN,
	// tries a request on TRIAL before committing it, and the checker runs on LIVE.
	localparam int PLAN  = 0;
	localparam int TRIAL = 1;
	localparam int LIVE  = 2;

	localparam int CYCLE_LIMIT  = 600000;
	localparam int STALL_CYCLES = 400;
	localparam int TAIL_CYCLES  = 60;

	typedef struct packed {
		logic              mode;
		logic [VIDX_W-1:0] origin;
		logic [VIDX_W-1:0] dest;
		logic              directed;
		logic [WGT_W-1:0]  weight;
	} edge_req_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [DEG_W-1:0]  degree;
	} edge_reply_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	logic              in_valid = 1'b0;
	logic              in_ready;
	edge_req_t         offered_req = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [STAT_W-1:0] status;
	logic [DEG_W-1:0]  origin_degree;

	// Register shadow, updated when the APB write lands.
	logic [CNT_W-1:0] cfg_vcount = CNT_W'(VERTICES);
	logic             cfg_weighted = 1'b0;

	// Adjacency state per copy. weight_known marks slots whose weight word was
	// ever written: moving an unwritten one is illegal, so such removes are avoided.
	logic [DEG_W-1:0]  deg_tab [3][VERTICES];
	logic [VIDX_W-1:0] nb_tab [3][VERTICES][MAX_DEGREE];
	bit                weight_known [3][VERTICES][MAX_DEGREE];
	bit                weight_hazard;

	edge_req_t   queued_edge_ops[$];
	edge_reply_t predicted_replies[$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit stall_go = 1'b0;
	logic hold_off = 1'b0;
	int error_count = 0;
	int cycle_count = 0;

	adjacency_list_edge_engine_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.mode         (offered_req.mode),
		.origin_vertex(offered_req.origin),
		.dest_vertex  (offered_req.dest),
		.directed     (offered_req.directed),
		.edge_weight  (offered_req.weight),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.origin_degree(origin_degree)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Vertex limit in effect: the register saturates at the store size, 0 rejects all.
	function automatic int vertex_limit();
		return (cfg_vcount > CNT_W'(VERTICES)) ? VERTICES : int'(cfg_vcount);
	endfunction

	// Append nb to list v of copy g; report a full list.
	function automatic bit list_append(input int g, input int v, input logic [VIDX_W-1:0] nb);
		int d;
		d = int'(deg_tab[g][v]);
		if (d >= MAX_DEGREE)
			return 1'b0;
		nb_tab[g][v][d] = nb;
		if (cfg_weighted)
			weight_known[g][v][d] = 1'b1;
		deg_tab[g][v] = DEG_W'(d + 1);
		return 1'b1;
	endfunction

	// Drop the first nb from list v of copy g: fill the hole with the last entry.
	function automatic bit list_drop(input int g, input int v, input logic [VIDX_W-1:0] nb);
		int d;
		int i;
		d = int'(deg_tab[g][v]);
		i = 0;
		while (i < d && nb_tab[g][v][i] != nb)
			i++;
		if (i >= d)
			return 1'b0;
		d--;
		deg_tab[g][v] = DEG_W'(d);
		nb_tab[g][v][i] = nb_tab[g][v][d];
		if (cfg_weighted) begin
			if (!weight_known[g][v][d])
				weight_hazard = 1'b1;
			weight_known[g][v][i] = weight_known[g][v][d];
		end
		return 1'b1;
	endfunction

	// Apply one edge request to copy g and return the reply the engine owes for it.
	function automatic edge_reply_t apply_edge_op(input int g, input edge_req_t r);
		edge_reply_t rep;
		int lim;
		lim = vertex_limit();
		rep.status = ST_DONE;
		rep.degree = '0;
		if (int'(r.origin) >= lim || int'(r.dest) >= lim) begin
			rep.status = ST_RANGE;
			return rep;
		end
		if (r.mode == MODE_INSERT) begin
			// a full reverse list keeps the forward edge but still flags full
			if (!list_append(g, int'(r.origin), r.dest))
				rep.status = ST_FULL;
			else if (!r.directed && !list_append(g, int'(r.dest), r.origin))
				rep.status = ST_FULL;
		end else begin
			// a missing reverse edge is ignored
			if (!list_drop(g, int'(r.origin), r.dest))
				rep.status = ST_MISSING;
			else if (!r.directed)
				void'(list_drop(g, int'(r.dest), r.origin));
		end
		rep.degree = deg_tab[g][r.origin];
		return rep;
	endfunction

	// Try the request on scratch copies of the two lists it touches; commit it to
	// the plan and the send queue only if it moves no unwritten weight word.
	function automatic bit queue_request(input edge_req_t r);
		int rows [2];
		rows[0] = int'(r.origin);
		rows[1] = int'(r.dest);
		foreach (rows[n]) begin
			deg_tab[TRIAL][rows[n]] = deg_tab[PLAN][rows[n]];
			for (int k = 0; k < MAX_DEGREE; k++) begin
				nb_tab[TRIAL][rows[n]][k] = nb_tab[PLAN][rows[n]][k];
				weight_known[TRIAL][rows[n]][k] = weight_known[PLAN][rows[n]][k];
			end
		end
		weight_hazard = 1'b0;
		void'(apply_edge_op(TRIAL, r));
		if (weight_hazard)
			return 1'b0;
		void'(apply_edge_op(PLAN, r));
		queued_edge_ops.push_back(r);
		return 1'b1;
	endfunction

	function automatic void queue_op(input logic m, input int o, input int d, input logic dir,
			input logic [WGT_W-1:0] w);
		edge_req_t r;
		r.mode = m;
		r.origin = VIDX_W'(o);
		r.dest = VIDX_W'(d);
		r.directed = dir;
		r.weight = w;
		void'(queue_request(r));
	endfunction

	// Mostly well-formed traffic: inserts, removes of edges that exist, some
	// removes of random pairs and a few stray vertex numbers.
	function automatic edge_req_t random_request();
		edge_req_t r;
		int lim;
		int roll;
		int v;
		int t;
		lim = vertex_limit();
		roll = $urandom_range(99);
		r.mode = MODE_INSERT;
		r.directed = 1'($urandom_range(1));
		r.weight = $urandom;
		r.origin = VIDX_W'($urandom_range(lim - 1));
		r.dest = VIDX_W'($urandom_range(lim - 1));
		if (roll < 5) begin
			r.origin = VIDX_W'($urandom);
			r.dest = VIDX_W'($urandom);
		end else if (roll >= 50 && roll < 60) begin
			r.mode = MODE_REMOVE;
		end else if (roll >= 60) begin
			r.mode = MODE_REMOVE;
			for (t = 0; t < 8; t++) begin
				v = $urandom_range(lim - 1);
				if (deg_tab[PLAN][v] != '0) begin
					r.origin = VIDX_W'(v);
					r.dest = nb_tab[PLAN][v][$urandom_range(int'(deg_tab[PLAN][v]) - 1)];
					break;
				end
			end
		end
		return r;
	endfunction

	task automatic queue_random_ops(input int count);
		edge_req_t r;
		int tries;
		repeat (count) begin
			tries = 0;
			r = random_request();
			// fall back to an insert, which never moves a weight word
			while (!queue_request(r)) begin
				tries++;
				r = random_request();
				if (tries > 8)
					r.mode = MODE_INSERT;
			end
		end
	endtask

	// APB write: setup, then access; the register lands on the access edge.
	task automatic cfg_write(input logic idx, input logic [PDATA_W-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'({idx, 2'b00});
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_VCOUNT)
			cfg_vcount = value[CNT_W-1:0];
		else
			cfg_weighted = value[0];
	endtask

	// Block until every queued request is taken and every reply has come back.
	task automatic wait_drained();
		@(negedge clk);
		while (queued_edge_ops.size() != 0 || in_valid || predicted_replies.size() != 0)
			@(negedge clk);
	endtask

	// Request driver: predict on acceptance, hold the payload while stalled,
	// insert random gaps between requests.
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				predicted_replies.push_back(apply_edge_op(LIVE, offered_req));
			if (!in_valid || in_ready) begin
				if (queued_edge_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					offered_req <= queued_edge_ops.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Reply monitor: compare each reply with the oldest prediction, then pick
	// the next ready level.
	always @(posedge clk) begin : reply_check
		edge_reply_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (predicted_replies.size() == 0) begin
					$error("reply with no request outstanding: status %0d origin_degree %0d",
						status, origin_degree);
					error_count++;
				end else begin
					want = predicted_replies.pop_front();
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						error_count++;
					end
					if (origin_degree !== want.degree) begin
						$error("origin_degree: expected %0d, got %0d", want.degree, origin_degree);
						error_count++;
					end
				end
			end
			out_ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Long receiver hold-off: the engine fills and must push back on requests.
	initial begin : long_stall
		wait (stall_go);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (STALL_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL adjacency_list_edge_engine_core");
			$finish;
		end
	end

	initial begin : stimulus
		foreach (deg_tab[g, v])
			deg_tab[g][v] = '0;
		foreach (weight_known[g, v, k])
			weight_known[g][v][k] = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		send_idle_pct = 34;
		recv_idle_pct = 67;

		// Weighted from the start so early slots carry written weight words.
		cfg_write(REG_WEIGHTED, 32'd1);
		cfg_write(REG_VCOUNT, 32'd64);
		queue_op(MODE_INSERT, 0, 63, 1'b1, 32'h0000_0000);
		queue_op(MODE_INSERT, 63, 0, 1'b0, 32'hFFFF_FFFF);
		// fill vertex 7 with undirected self loops: two entries each
		repeat (8) queue_op(MODE_INSERT, 7, 7, 1'b0, $urandom);
		queue_op(MODE_INSERT, 7, 1, 1'b1, 32'h5A5A_A5A5);      // origin list full
		queue_op(MODE_INSERT, 1, 7, 1'b0, 32'hA5A5_5A5A);      // reverse list full
		queue_op(MODE_REMOVE, 7, 7, 1'b0, 32'h0);              // self loop removed twice
		queue_op(MODE_REMOVE, 0, 5, 1'b1, 32'h0);              // edge missing
		queue_op(MODE_REMOVE, 0, 63, 1'b0, 32'h0);             // both directions present
		queue_op(MODE_REMOVE, 1, 7, 1'b0, 32'h0);              // reverse edge missing
		queue_op(MODE_REMOVE, 63, 0, 1'b1, 32'h0);
		wait_drained();

		// Smallest useful vertex count: only vertex 0 passes.
		cfg_write(REG_VCOUNT, 32'd1);
		queue_op(MODE_INSERT, 0, 0, 1'b1, 32'h1234_5678);
		queue_op(MODE_INSERT, 0, 1, 1'b1, 32'h0);
		queue_op(MODE_REMOVE, 1, 0, 1'b0, 32'h0);
		wait_drained();

		// Zero rejects every request.
		cfg_write(REG_VCOUNT, 32'd0);
		queue_op(MODE_INSERT, 0, 0, 1'b0, 32'h0);
		wait_drained();

		// Oversized count saturates, so vertex 63 stays reachable.
		cfg_write(REG_VCOUNT, 32'd127);
		cfg_write(REG_WEIGHTED, 32'd0);
		queue_op(MODE_INSERT, 63, 63, 1'b0, 32'hDEAD_BEEF);
		queue_op(MODE_REMOVE, 63, 63, 1'b1, 32'h0);
		wait_drained();

		// Sparse graph, weighted; the sender pauses halfway until drained.
		cfg_write(REG_VCOUNT, 32'd64);
		cfg_write(REG_WEIGHTED, 32'd1);
		queue_random_ops(275);
		wait_drained();
		queue_random_ops(275);
		wait_drained();

		// Dense graph on five vertices: lists run full, stray vertices rejected.
		send_idle_pct = 67;
		recv_idle_pct = 34;
		cfg_write(REG_VCOUNT, 32'd5);
		cfg_write(REG_WEIGHTED, 32'd0);
		queue_random_ops(400);
		wait_drained();

		// No idling, weighted again, with one long receiver hold-off.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		cfg_write(REG_VCOUNT, 32'd100);
		cfg_write(REG_WEIGHTED, 32'd1);
		stall_go = 1'b1;
		queue_random_ops(400);
		wait_drained();

		// Catch any stray reply after the last one.
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0 && predicted_replies.size() == 0)
			$display("PASS adjacency_list_edge_engine_core");
		else
			$display("FAIL adjacency_list_edge_engine_core");
		$finish;
	end
endmodule

// ===== adjacency_list_edge_engine_core.f =====
+incdir+hw/rtl
hw/rtl/alee_pkg.sv
hw/rtl/alee_deg_mem.sv
hw/rtl/alee_list_mem.sv
hw/rtl/alee_ctrl.sv
hw/rtl/adjacency_list_edge_engine_core.sv
dv/adjacency_list_edge_engine_core_tb.sv
